### rtl/core/bpfa_pkg.sv
// bpfa_pkg: shared types, codes and defaults for the bitmap page frame allocator
// used by bpfa_regs, bpfa_ctrl, bpfa_dp and the top level; no dependencies
package bpfa_pkg;

    localparam int ADDR_W    = 48;
    localparam int CNT_W     = 13;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;

    localparam int MAX_PAGES_DEF  = 4096;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int WORD_BITS_DEF  = 64;

    localparam logic [ADDR_W-1:0] RST_REGION_BASE    = '0;
    localparam logic [CNT_W-1:0]  RST_PAGE_COUNT     = CNT_W'(4096);
    localparam logic [CNT_W-1:0]  RST_RESERVED_PAGES = CNT_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 2'd0,
        STS_NONE_FREE = 2'd1,
        STS_IGNORED   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_REGION_BASE    = 2'd0,
        REG_PAGE_COUNT     = 2'd1,
        REG_RESERVED_PAGES = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_ALLOC_WR,
        ST_FREE_CALC,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sweep;
        logic scan;
        logic alloc_wr;
        logic free_calc;
        logic free_rd;
        logic free_wr;
        logic res_done;
        logic res_none;
        logic res_ign;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic hit;
        logic scan_end;
    } dp_status_t;

endpackage

### rtl/core/bpfa_regs.sv
// bpfa_regs: apb-style configuration registers of the page frame allocator
// depends on bpfa_pkg
module bpfa_regs
    import bpfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ADDR_W-1:0]  region_base,
    output logic [CNT_W-1:0]   page_count,
    output logic [CNT_W-1:0]   reserved_pages
);

    logic [ADDR_W-1:0] region_base_reg;
    logic [CNT_W-1:0]  page_count_reg;
    logic [CNT_W-1:0]  reserved_pages_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg    <= RST_REGION_BASE;
            page_count_reg     <= RST_PAGE_COUNT;
            reserved_pages_reg <= RST_RESERVED_PAGES;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_REGION_BASE:    region_base_reg    <= pwdata[ADDR_W-1:0];
                REG_PAGE_COUNT:     page_count_reg     <= pwdata[CNT_W-1:0];
                REG_RESERVED_PAGES: reserved_pages_reg <= pwdata[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_REGION_BASE:    prdata = PDATA_W'(region_base_reg);
            REG_PAGE_COUNT:     prdata = PDATA_W'(page_count_reg);
            REG_RESERVED_PAGES: prdata = PDATA_W'(reserved_pages_reg);
            default:            prdata = '0;
        endcase
    end

    assign region_base    = region_base_reg;
    assign page_count     = page_count_reg;
    assign reserved_pages = reserved_pages_reg;

endmodule

### rtl/core/bpfa_ctrl.sv
// bpfa_ctrl: command sequencer of the page frame allocator
// depends on bpfa_pkg; drives bpfa_dp through ctrl_cmd_t
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] cmd,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output ctrl_cmd_t        ctl,
    input  dp_status_t       sts
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   cmd_known;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cmd_known = (cmd == CMD_INIT) || (cmd == CMD_ALLOC) || (cmd == CMD_FREE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(cmd))
                        CMD_INIT:  state_next = ST_INIT;
                        CMD_ALLOC: state_next = ST_SCAN;
                        CMD_FREE:  state_next = ST_FREE_CALC;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_INIT:
            begin
                if (sts.sweep_last)
                    state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                if (sts.hit)
                    state_next = ST_ALLOC_WR;
                else if (sts.scan_end)
                    state_next = ST_RESP;
            end
            ST_ALLOC_WR:  state_next = ST_RESP;
            ST_FREE_CALC: state_next = ST_FREE_RD;
            ST_FREE_RD:   state_next = ST_FREE_WR;
            ST_FREE_WR:   state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:     ctl.sweep = 1'b1;
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.load    = in_valid;
                ctl.res_ign = in_valid && !cmd_known;
            end
            ST_INIT:
            begin
                ctl.sweep    = 1'b1;
                ctl.res_done = sts.sweep_last;
            end
            ST_SCAN:
            begin
                ctl.scan     = 1'b1;
                ctl.res_none = sts.scan_end;
            end
            ST_ALLOC_WR:  ctl.alloc_wr  = 1'b1;
            ST_FREE_CALC: ctl.free_calc = 1'b1;
            ST_FREE_RD:   ctl.free_rd   = 1'b1;
            ST_FREE_WR:   ctl.free_wr   = 1'b1;
            ST_RESP:      ctl.out_load  = out_free;
            default:      ;
        endcase
    end

    assign out_valid_next = ctl.out_load || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while a result waits");

    // a page is only written after the scan found a free bit
    a_alloc_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC_WR) |-> ($past(state_reg) == ST_SCAN && $past(sts.hit)))
        else $error("allocation write without a scan hit");

    // a loaded result is offered in the following cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> out_valid_reg)
        else $error("loaded result not offered");

endmodule

### rtl/core/bpfa_dp.sv
// bpfa_dp: usage bitmap memory, scan, init sweep and free path of the allocator
// depends on bpfa_pkg; sequenced by bpfa_ctrl
module bpfa_dp
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           ctl,
    output dp_status_t          sts,
    input  logic [ADDR_W-1:0]   address,
    input  logic [ADDR_W-1:0]   region_base,
    input  logic [CNT_W-1:0]    page_count,
    input  logic [CNT_W-1:0]    reserved_pages,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   page_address
);

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PIDX_W    = WIDX_W + BIT_W;
    localparam int MAXP_W    = $clog2(MAX_PAGES + 1);
    localparam int LIM_W     = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;
    localparam int PG_W      = ADDR_W - PAGE_SHIFT;
    localparam int CMP_W     = (PG_W > LIM_W) ? PG_W : LIM_W;
    localparam logic [WORD_BITS-1:0] ONE_W    = WORD_BITS'(1);
    localparam logic [LIM_W-1:0]     WB_L     = LIM_W'(WORD_BITS);
    localparam logic [LIM_W-1:0]     MAXP_L   = LIM_W'(MAX_PAGES);
    localparam logic [WIDX_W:0]      NWORDS_C = (WIDX_W+1)'(MAP_WORDS);
    localparam logic [WIDX_W:0]      LASTW_C  = (WIDX_W+1)'(MAP_WORDS - 1);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [LIM_W-1:0]     limit_reg;
    logic [LIM_W-1:0]     rem_reg;
    logic [LIM_W-1:0]     rem_next;
    logic [WIDX_W:0]      wcnt_reg;
    logic [WIDX_W:0]      wcnt_next;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 chk_vld_reg;
    logic [WIDX_W-1:0]    chk_word_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WIDX_W-1:0]    hit_word_reg;
    logic [BIT_W-1:0]     hit_bit_reg;
    logic [WORD_BITS-1:0] hit_data_reg;
    logic [ADDR_W-1:0]    diff_reg;
    logic                 bad_reg;
    logic [WIDX_W-1:0]    free_word_reg;
    logic [BIT_W-1:0]     free_bit_reg;
    logic                 ign_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [ADDR_W-1:0]    out_addr_reg;

    logic [LIM_W-1:0]     page_count_l;
    logic [LIM_W-1:0]     reserved_l;
    logic [LIM_W-1:0]     limit_clamp;
    logic [LIM_W-1:0]     res_clamp;
    logic                 scan_issue;
    logic [WIDX_W-1:0]    widx;
    logic [WORD_BITS-1:0] init_word;
    logic [LIM_W-1:0]     lim_word;
    logic [LIM_W-1:0]     chk_ext;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_mask;
    logic [BIT_W-1:0]     first_bit;
    logic [PG_W-1:0]      pg;
    logic                 ign_next;
    logic [PIDX_W-1:0]    hit_page;
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign page_count_l = LIM_W'(page_count);
    assign reserved_l   = LIM_W'(reserved_pages);
    assign limit_clamp  = (page_count_l > MAXP_L) ? MAXP_L : page_count_l;
    assign res_clamp    = (reserved_l > MAXP_L) ? MAXP_L : reserved_l;

    assign widx       = wcnt_reg[WIDX_W-1:0];
    assign scan_issue = ctl.scan && (wcnt_reg < NWORDS_C);

    // init pattern: all ones while a full word of reserved pages remains
    assign init_word = (rem_reg >= WB_L) ? '1 : ((ONE_W << rem_reg[BIT_W-1:0]) - ONE_W);
    assign rem_next  = (rem_reg >= WB_L) ? (rem_reg - WB_L) : '0;

    // pages at or above the limit count as used
    assign lim_word = limit_reg >> BIT_W;
    assign chk_ext  = LIM_W'(chk_word_reg);

    always_comb
    begin
        if (chk_ext < lim_word)
            valid_mask = '1;
        else if (chk_ext == lim_word)
            valid_mask = (ONE_W << limit_reg[BIT_W-1:0]) - ONE_W;
        else
            valid_mask = '0;
    end

    assign free_mask = ~rd_data_reg & valid_mask;

    always_comb
    begin
        first_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
                first_bit = BIT_W'(i);
        end
    end

    assign sts.hit        = chk_vld_reg && (|free_mask);
    assign sts.scan_end   = chk_vld_reg && (|free_mask) == 1'b0
                            && ({1'b0, chk_word_reg} == LASTW_C);
    assign sts.sweep_last = (wcnt_reg == LASTW_C);

    assign pg       = diff_reg[ADDR_W-1:PAGE_SHIFT];
    assign ign_next = bad_reg || (CMP_W'(pg) >= CMP_W'(limit_reg));
    assign hit_page = {hit_word_reg, hit_bit_reg};

    always_comb
    begin
        if (ctl.load)
            wcnt_next = '0;
        else if (ctl.sweep || scan_issue)
            wcnt_next = wcnt_reg + (WIDX_W+1)'(1);
        else
            wcnt_next = wcnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg    <= '0;
            rem_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            wcnt_reg    <= wcnt_next;
            chk_vld_reg <= scan_issue;
            if (ctl.load)
                rem_reg <= res_clamp;
            else if (ctl.sweep)
                rem_reg <= rem_next;
        end
    end

    // memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = widx;
        wr_en   = 1'b0;
        wr_addr = widx;
        wr_data = init_word;
        if (scan_issue)
        begin
            rd_en = 1'b1;
        end
        else if (ctl.free_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = pg[PIDX_W-1:BIT_W];
        end
        if (ctl.sweep)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.alloc_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = hit_word_reg;
            wr_data = hit_data_reg | (ONE_W << hit_bit_reg);
        end
        else if (ctl.free_wr && !ign_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = free_word_reg;
            wr_data = rd_data_reg & ~(ONE_W << free_bit_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            addr_reg  <= address;
            limit_reg <= limit_clamp;
        end
        if (scan_issue)
            chk_word_reg <= widx;
        if (ctl.scan && sts.hit)
        begin
            hit_word_reg <= chk_word_reg;
            hit_bit_reg  <= first_bit;
            hit_data_reg <= rd_data_reg;
        end
        if (ctl.free_calc)
        begin
            diff_reg <= addr_reg - region_base;
            bad_reg  <= (addr_reg == '0) || (addr_reg < region_base);
        end
        if (ctl.free_rd)
        begin
            ign_reg       <= ign_next;
            free_word_reg <= pg[PIDX_W-1:BIT_W];
            free_bit_reg  <= pg[BIT_W-1:0];
        end
        if (ctl.res_done)
        begin
            res_status_reg <= STS_DONE;
            res_addr_reg   <= '0;
        end
        else if (ctl.res_none)
        begin
            res_status_reg <= STS_NONE_FREE;
            res_addr_reg   <= '0;
        end
        else if (ctl.res_ign)
        begin
            res_status_reg <= STS_IGNORED;
            res_addr_reg   <= '0;
        end
        else if (ctl.alloc_wr)
        begin
            res_status_reg <= STS_DONE;
            res_addr_reg   <= region_base + (ADDR_W'(hit_page) << PAGE_SHIFT);
        end
        else if (ctl.free_wr)
        begin
            res_status_reg <= ign_reg ? STS_IGNORED : STS_DONE;
            res_addr_reg   <= '0;
        end
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    assign status       = out_status_reg;
    assign page_address = out_addr_reg;

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_addr} < NWORDS_C))
        else $error("bitmap write beyond the last word");

    // the page handed out was free in the word that was read
    a_alloc_free_bit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc_wr |-> !hit_data_reg[hit_bit_reg])
        else $error("allocated page was already in use");

    a_hit_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan && sts.hit) |-> valid_mask[first_bit])
        else $error("scan hit above the page limit");

endmodule

### rtl/core/bitmap_page_frame_allocator_top.sv
// bitmap_page_frame_allocator_top: first-fit page frame allocator over a usage bitmap
// depends on bpfa_pkg, bpfa_regs, bpfa_ctrl and bpfa_dp
//
// Commands come in on the input channel (in_valid, in_stall, cmd, address); one
// result per command leaves on the output channel (out_valid, out_stall, status,
// page_address). A transfer happens when valid is high and stall is low.
// The bitmap holds MAX_PAGES/WORD_BITS words, rounded up, in one memory with one
// port each for read and write; commands step through it one word at a time:
//   init   writes every bitmap word in turn (one bitmap word written per cycle)
//   alloc  reads words from word 0 up to the first with a free page, or all
//          words when none is free (one word read and checked per cycle)
//   free   subtract, read, write back, result
//   unused command goes straight to the result
// One command is in progress at a time; the next is taken once the previous
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds, and the block then waits in its response state.
// After reset the bitmap is cleared by a sweep over all MAP_WORDS words (64 at the
// default size) during which in_stall stays high; the apb port works throughout.
// Configuration registers sit at byte addresses 0, 8 and 16 and must only be
// written while no command is in progress.
module bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [ADDR_W-1:0]   address,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   page_address,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [ADDR_W-1:0] region_base;
    logic [CNT_W-1:0]  page_count;
    logic [CNT_W-1:0]  reserved_pages;
    ctrl_cmd_t         ctl;
    dp_status_t        sts;

    bpfa_regs u_regs
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .region_base    (region_base),
        .page_count     (page_count),
        .reserved_pages (reserved_pages)
    );

    bpfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    bpfa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .WORD_BITS  (WORD_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .address        (address),
        .region_base    (region_base),
        .page_count     (page_count),
        .reserved_pages (reserved_pages),
        .status         (status),
        .page_address   (page_address)
    );

endmodule

### tb/tb_bitmap_page_frame_allocator_top.sv
// tb_bitmap_page_frame_allocator_top: self-checking bench for the first-fit page allocator
// drives commands and apb register writes, predicts every result and compares it
// depends on bpfa_pkg and bitmap_page_frame_allocator_top
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   page_address;
    } result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd = '0;
    logic [ADDR_W-1:0]   address = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // predicted allocator state
    bit [MAX_PAGES_DEF-1:0] page_used = '0;
    logic [ADDR_W-1:0]      cur_base = RST_REGION_BASE;
    logic [CNT_W-1:0]       cur_count = RST_PAGE_COUNT;
    logic [CNT_W-1:0]       cur_reserved = RST_RESERVED_PAGES;

    result_t pending_q[$];
    int      errors = 0;
    int      cycles = 0;
    bit      idle_en = 1'b1;
    bit      hold_req = 1'b0;
    int      hold_left = 0;

    bitmap_page_frame_allocator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .page_address (page_address),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_bitmap_page_frame_allocator_top: done, errors");
            $finish;
        end
    end

    function automatic int clamp_pages(input logic [CNT_W-1:0] n);
        return (n > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(n);
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [ADDR_W-1:0] page_addr(input int p, input int offset);
        return cur_base + (ADDR_W'(p) << PAGE_SHIFT_DEF) + ADDR_W'(offset);
    endfunction

    // applies one command to the predicted bitmap and returns its result
    function automatic result_t predict_command(input logic [CMD_W-1:0] c,
                                                input logic [ADDR_W-1:0] a);
        result_t           r;
        int                lim;
        int                res;
        logic [ADDR_W-1:0] idx;
        r.status       = STS_DONE;
        r.page_address = '0;
        lim = clamp_pages(cur_count);
        res = clamp_pages(cur_reserved);
        case (c)
            CMD_INIT:
            begin
                page_used = '0;
                for (int p = 0; p < res; p++)
                    page_used[p] = 1'b1;
            end
            CMD_ALLOC:
            begin
                r.status = STS_NONE_FREE;
                for (int p = 0; p < lim; p++)
                begin
                    if (!page_used[p])
                    begin
                        page_used[p]   = 1'b1;
                        r.page_address = cur_base + (ADDR_W'(p) << PAGE_SHIFT_DEF);
                        r.status       = STS_DONE;
                        break;
                    end
                end
            end
            CMD_FREE:
            begin
                if (a == '0 || a < cur_base)
                    r.status = STS_IGNORED;
                else
                begin
                    idx = (a - cur_base) >> PAGE_SHIFT_DEF;
                    if (idx >= ADDR_W'(lim))
                        r.status = STS_IGNORED;
                    else
                        page_used[int'(idx)] = 1'b0;
                end
            end
            default:
                r.status = STS_IGNORED;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d page_address %h",
                         $time, status, page_address);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (page_address !== want.page_address)
                begin
                    $display("%0t: page_address mismatch, expected %h actual %h",
                             $time, want.page_address, page_address);
                    errors++;
                end
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_en && ($urandom_range(99) < 22);
    end

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a);
        if (idle_en)
            while ($urandom_range(99) < 22)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        cmd      <= c;
        address  <= a;
        do
            @(posedge clk);
        while (in_stall);
        pending_q.push_back(predict_command(c, a));
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        // let the block settle back to idle before any register write
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REGION_BASE:    cur_base = val[ADDR_W-1:0];
            REG_PAGE_COUNT:     cur_count = val[CNT_W-1:0];
            REG_RESERVED_PAGES: cur_reserved = val[CNT_W-1:0];
            default:            ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [PDATA_W-1:0] base,
                              input logic [PDATA_W-1:0] count,
                              input logic [PDATA_W-1:0] reserved);
        write_reg(REG_REGION_BASE, base);
        write_reg(REG_PAGE_COUNT, count);
        write_reg(REG_RESERVED_PAGES, reserved);
    endtask

    // map is clear out of reset and registers hold their reset values
    task automatic test_reset_defaults();
        send_cmd(CMD_ALLOC, rand48());
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_FREE, '0);
        send_cmd(CMD_FREE, 48'h1000);
        send_cmd(CMD_FREE, 48'h1abc);
        send_cmd(CMD_FREE, 48'h100_0000);
        send_cmd(CMD_UNUSED, rand48());
        send_cmd(CMD_INIT, '0);
        send_cmd(CMD_ALLOC, '0);
        wait_results();
    endtask

    task automatic test_config_extremes();
        // all-ones writes: counts clamp to capacity, base unaligned at the top
        set_config('1, '1, '1);
        send_cmd(CMD_INIT, '0);
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_FREE, 48'hFFFF_FFFF_FFFF);
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_FREE, 48'hFFFF_FFFF_FFFE);
        wait_results();
        // nothing managed at all
        set_config('0, '0, '0);
        send_cmd(CMD_INIT, '0);
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_FREE, 48'h1000);
        wait_results();
        // last page of a full-size region, address wraps
        set_config(48'hFFFF_FFFF_F000, 4096, 4095);
        send_cmd(CMD_INIT, '0);
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_ALLOC, '0);
        wait_results();
        // reserved pages run past the managed ones
        set_config(48'h0000_0040_0000, 4, 10);
        send_cmd(CMD_INIT, '0);
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_FREE, page_addr(2, 12'h123));
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_FREE, page_addr(4, 0));
        wait_results();
    endtask

    // receiver holds off while allocs keep coming, so the input stalls
    task automatic test_backpressure();
        set_config(rand48() & ~48'hFFF, 64, 2);
        send_cmd(CMD_INIT, '0);
        hold_req = 1'b1;
        idle_en  = 1'b0;
        repeat (30) send_cmd(CMD_ALLOC, rand48());
        idle_en = 1'b1;
        wait_results();
    endtask

    task automatic random_config();
        logic [ADDR_W-1:0] base;
        int                pc;
        int                cap;
        int                rs;
        int                sel;
        sel = $urandom_range(99);
        if (sel < 60)
            base = rand48() & ~48'hFFF;
        else if (sel < 80)
            base = '0;
        else if (sel < 90)
            base = (rand48() | 48'hFFFF_F000_0000) & ~48'hFFF;
        else
            base = rand48();
        sel = $urandom_range(99);
        if (sel < 70)
            pc = $urandom_range(1, 128);
        else if (sel < 80)
            pc = MAX_PAGES_DEF;
        else if (sel < 85)
            pc = 0;
        else if (sel < 90)
            pc = $urandom_range(MAX_PAGES_DEF + 1, 8191);
        else
            pc = $urandom_range(129, MAX_PAGES_DEF - 1);
        cap = (pc > MAX_PAGES_DEF) ? MAX_PAGES_DEF : pc;
        sel = $urandom_range(99);
        if (sel < 60)
            rs = $urandom_range(0, cap / 2);
        else if (sel < 80)
            rs = 0;
        else if (sel < 90)
            rs = pc;
        else
            rs = $urandom_range(0, 8191);
        set_config(PDATA_W'(base), PDATA_W'(pc), PDATA_W'(rs));
    endtask

    task automatic random_item();
        int                pick;
        int                lim;
        int                p;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(99);
        lim  = clamp_pages(cur_count);
        a    = rand48();
        if (pick < 45)
            send_cmd(CMD_ALLOC, a);
        else if (pick < 80)
        begin
            if (lim == 0)
                send_cmd(CMD_FREE, a);
            else
            begin
                // lean towards pages that are in use
                p = $urandom_range(lim - 1);
                repeat (6)
                    if (!page_used[p])
                        p = $urandom_range(lim - 1);
                send_cmd(CMD_FREE, page_addr(p, $urandom_range(4095)));
            end
        end
        else if (pick < 90)
        begin
            case ($urandom_range(3))
                0: a = '0;
                1: a = rand48();
                2: a = cur_base - ADDR_W'($urandom_range(1, 4096));
                default: a = page_addr(lim, $urandom_range(4095));
            endcase
            send_cmd(CMD_FREE, a);
        end
        else if (pick < 95)
            send_cmd(CMD_INIT, a);
        else
            send_cmd(CMD_UNUSED, a);
    endtask

    task automatic test_random(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            random_config();
            // one phase runs with no idling on either side
            idle_en = (ph != 2);
            send_cmd(CMD_INIT, rand48());
            repeat (per_phase) random_item();
            wait_results();
            idle_en = 1'b1;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_backpressure();
        test_random(8, 50);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_bitmap_page_frame_allocator_top: done, clean");
        else
            $display("tb_bitmap_page_frame_allocator_top: done, errors");
        $finish;
    end

endmodule

### sim.f
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_regs.sv
rtl/core/bpfa_ctrl.sv
rtl/core/bpfa_dp.sv
rtl/core/bitmap_page_frame_allocator_top.sv
tb/tb_bitmap_page_frame_allocator_top.sv
